// File: sv/hcvd_pkg.sv
// Shared types and constants of the heating curve valve decision block.
package hcvd_pkg;

  // Field widths
  localparam int TEMP_W     = 13;                // temperatures, signed 1/16 degC
  localparam int DIFF_W     = TEMP_W + 1;        // difference of two temperatures
  localparam int PROD_W     = 2 * DIFF_W;        // curve numerator product
  localparam int MAG_W      = PROD_W - 1;        // magnitude of the numerator
  localparam int DIV_W      = DIFF_W - 1;        // magnitude of the span
  localparam int SUM_W      = PROD_W + 1;        // unclamped target
  localparam int TOL_W      = 11;
  localparam int TIME_W     = 16;
  localparam int BEY_W      = TEMP_W;            // excess beyond the band
  localparam int MUL_W      = TIME_W + BEY_W;    // gain times excess
  localparam int RUN_W      = MUL_W - 4 + 1;     // base time plus scaled product
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  // Register indexes of the configuration port
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_FLOW_LOW    = 3'd0,
    REG_FLOW_HIGH   = 3'd1,
    REG_RETURN_LOW  = 3'd2,
    REG_RETURN_HIGH = 3'd3,
    REG_TOLERANCE   = 3'd4,
    REG_MIN_TIME    = 3'd5,
    REG_GAIN_CLOSE  = 3'd6,
    REG_GAIN_OPEN   = 3'd7
  } hcvd_reg_e;

  // Valve motion codes
  typedef enum logic [1:0] {
    DIR_HALT  = 2'd0,
    DIR_CLOSE = 2'd1,
    DIR_OPEN  = 2'd2
  } hcvd_dir_e;

  // Fixed results and reset values
  localparam logic [TEMP_W-1:0] ERROR_TARGET    = 13'h19C2;  // -1598, i.e. -99.9 degC
  localparam logic [TEMP_W-1:0] SUMMER_TARGET   = 13'h0000;
  localparam logic [TIME_W-1:0] TIME_MAX        = 16'hFFFF;
  localparam logic [TEMP_W-1:0] RST_FLOW_LOW    = 13'd320;
  localparam logic [TEMP_W-1:0] RST_FLOW_HIGH   = 13'd1120;
  localparam logic [TEMP_W-1:0] RST_RETURN_LOW  = 13'd320;
  localparam logic [TEMP_W-1:0] RST_RETURN_HIGH = 13'd800;
  localparam logic [TOL_W-1:0]  RST_TOLERANCE   = 11'd32;
  localparam logic [TIME_W-1:0] RST_MIN_TIME    = 16'd1000;
  localparam logic [TIME_W-1:0] RST_GAIN_CLOSE  = 16'd1000;
  localparam logic [TIME_W-1:0] RST_GAIN_OPEN   = 16'd1000;

  // Configuration as seen by the datapath
  typedef struct packed {
    logic [TEMP_W-1:0] flow_low;
    logic [TEMP_W-1:0] flow_high;
    logic [TEMP_W-1:0] ret_low;
    logic [TEMP_W-1:0] ret_high;
    logic [TOL_W-1:0]  tol;
    logic [TIME_W-1:0] min_time;
    logic [TIME_W-1:0] gain_close;
    logic [TIME_W-1:0] gain_open;
  } hcvd_cfg_t;

  // Classified sample handed from the front part to the back part
  typedef struct packed {
    logic              err;
    logic              summer;
    logic              zero_span;
    logic              flow_gt;
    logic [TEMP_W-1:0] ret;
    logic [PROD_W-1:0] prod;
    logic [DIFF_W-1:0] span;
  } hcvd_item_t;

  // Flags that ride alongside the divider
  typedef struct packed {
    logic              err;
    logic              summer;
    logic              zero_span;
    logic              flow_gt;
    logic              neg;
    logic [TEMP_W-1:0] ret;
  } hcvd_side_t;

endpackage

// File: sv/hcvd_front.sv
// Front part: takes samples, forms the curve numerator and span, classifies them.
module hcvd_front import hcvd_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  hcvd_cfg_t              cfg_i,
  input  logic                   s_valid_i,
  output logic                   s_ready_o,
  input  logic [TEMP_W-1:0]      flow_i,
  input  logic [TEMP_W-1:0]      ret_i,
  input  logic                   err_i,
  input  logic                   summer_i,
  input  logic                   full_i,
  output logic                   push_o,
  output hcvd_item_t             item_o
);

  logic                     valid_q, valid_d;
  hcvd_item_t               item_q, item_d;
  logic                     accept;
  logic signed [DIFF_W-1:0] flow_diff, ret_diff, span;
  logic signed [PROD_W-1:0] prod;

  // Curve terms: numerator product and span
  always_comb begin
    flow_diff = $signed({flow_i[TEMP_W-1], flow_i})
              - $signed({cfg_i.flow_low[TEMP_W-1], cfg_i.flow_low});
    ret_diff  = $signed({cfg_i.ret_high[TEMP_W-1], cfg_i.ret_high})
              - $signed({cfg_i.ret_low[TEMP_W-1], cfg_i.ret_low});
    span      = $signed({cfg_i.flow_high[TEMP_W-1], cfg_i.flow_high})
              - $signed({cfg_i.flow_low[TEMP_W-1], cfg_i.flow_low});
    prod      = ret_diff * flow_diff;
    item_d.err       = err_i;
    item_d.summer    = summer_i;
    item_d.zero_span = (cfg_i.flow_high == cfg_i.flow_low);
    item_d.flow_gt   = ($signed(flow_i) > $signed(cfg_i.flow_low));
    item_d.ret       = ret_i;
    item_d.prod      = prod;
    item_d.span      = span;
  end

  // Hand over to the queue whenever it has room
  assign push_o    = valid_q && !full_i;
  assign s_ready_o = !valid_q || !full_i;
  assign accept    = s_valid_i && s_ready_o;
  assign item_o    = item_q;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Capture the sample on transfer
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

endmodule

// File: sv/hcvd_queue.sv
// Short queue between the front and back parts.
module hcvd_queue import hcvd_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  hcvd_item_t item_i,
  input  logic       pop_i,
  output hcvd_item_t item_o,
  output logic       full_o,
  output logic       empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  hcvd_item_t       mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign item_o  = mem_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the entry
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// File: sv/hcvd_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module hcvd_div import hcvd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [MAG_W-1:0] dividend_i,
  input  logic [DIV_W-1:0] divisor_i,
  input  hcvd_side_t       side_i,
  output logic             valid_o,
  output logic [MAG_W-1:0] quot_o,
  output hcvd_side_t       side_o
);

  // Index 0 is the input, index k the register after stage k
  logic [MAG_W:0]   vld;
  logic [DIV_W-1:0] rem  [MAG_W+1];
  logic [MAG_W-1:0] nq   [MAG_W+1];
  logic [DIV_W-1:0] dv   [MAG_W+1];
  hcvd_side_t       side [MAG_W+1];

  assign vld[0]  = valid_i;
  assign rem[0]  = '0;
  assign nq[0]   = dividend_i;
  assign dv[0]   = divisor_i;
  assign side[0] = side_i;

  for (genvar k = 0; k < MAG_W; k++) begin : g_stage
    logic [DIV_W:0] trial;
    logic [DIV_W:0] diff;
    logic           ge;

    // Shift in the next dividend bit and try the subtraction
    always_comb begin
      trial = {rem[k], nq[k][MAG_W-1]};
      diff  = trial - {1'b0, dv[k]};
      ge    = (trial >= {1'b0, dv[k]});
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld[k+1] <= 1'b0;
      end else if (en_i) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem[k+1]  <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
        nq[k+1]   <= {nq[k][MAG_W-2:0], ge};
        dv[k+1]   <= dv[k];
        side[k+1] <= side[k];
      end
    end
  end

  assign valid_o = vld[MAG_W];
  assign quot_o  = nq[MAG_W];
  assign side_o  = side[MAG_W];

endmodule

// File: sv/hcvd_back.sv
// Back part: divides, clamps the target, decides direction and motor time.
module hcvd_back import hcvd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hcvd_cfg_t         cfg_i,
  input  logic              empty_i,
  input  hcvd_item_t        item_i,
  output logic              pop_o,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  output logic [1:0]        dir_o,
  output logic [TIME_W-1:0] time_o,
  output logic [TEMP_W-1:0] target_o
);

  logic adv;

  // Whole pipeline moves unless the output holds an untaken result
  assign adv   = !m_valid_o || m_ready_i;
  assign pop_o = adv && !empty_i;

  // Stage 0: magnitudes and quotient sign
  logic             s0_valid_q;
  logic [MAG_W-1:0] s0_mag_q;
  logic [DIV_W-1:0] s0_dv_q;
  hcvd_side_t       s0_side_q;
  logic [PROD_W-1:0] prod_abs;
  logic [DIFF_W-1:0] span_abs;
  hcvd_side_t        s0_side_d;

  always_comb begin
    prod_abs = item_i.prod[PROD_W-1] ? (~item_i.prod + 1'b1) : item_i.prod;
    span_abs = item_i.span[DIFF_W-1] ? (~item_i.span + 1'b1) : item_i.span;
    s0_side_d.err       = item_i.err;
    s0_side_d.summer    = item_i.summer;
    s0_side_d.zero_span = item_i.zero_span;
    s0_side_d.flow_gt   = item_i.flow_gt;
    s0_side_d.neg       = item_i.prod[PROD_W-1] ^ item_i.span[DIFF_W-1];
    s0_side_d.ret       = item_i.ret;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (adv) begin
      s0_valid_q <= !empty_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_mag_q  <= prod_abs[MAG_W-1:0];
      s0_dv_q   <= span_abs[DIV_W-1:0];
      s0_side_q <= s0_side_d;
    end
  end

  // Divider
  logic             dq_valid;
  logic [MAG_W-1:0] dq_quot;
  hcvd_side_t       dq_side;

  hcvd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (adv),
    .valid_i    (s0_valid_q),
    .dividend_i (s0_mag_q),
    .divisor_i  (s0_dv_q),
    .side_i     (s0_side_q),
    .valid_o    (dq_valid),
    .quot_o     (dq_quot),
    .side_o     (dq_side)
  );

  // Stage A: signed quotient plus low return point
  logic                    sa_valid_q;
  logic signed [SUM_W-1:0] sa_sum_q;
  hcvd_side_t              sa_side_q;
  logic signed [PROD_W-1:0] q_signed;
  logic signed [SUM_W-1:0]  ret_low_x, ret_high_x;

  assign ret_low_x  = $signed({{(SUM_W-TEMP_W){cfg_i.ret_low[TEMP_W-1]}}, cfg_i.ret_low});
  assign ret_high_x = $signed({{(SUM_W-TEMP_W){cfg_i.ret_high[TEMP_W-1]}}, cfg_i.ret_high});

  always_comb begin
    q_signed = dq_side.neg ? -$signed({1'b0, dq_quot}) : $signed({1'b0, dq_quot});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sa_valid_q <= 1'b0;
    end else if (adv) begin
      sa_valid_q <= dq_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sa_sum_q  <= ret_low_x + $signed({q_signed[PROD_W-1], q_signed});
      sa_side_q <= dq_side;
    end
  end

  // Stage B: clamp low then high, or pick a point on zero span
  logic              sb_valid_q;
  logic [TEMP_W-1:0] sb_target_q;
  hcvd_side_t        sb_side_q;
  logic signed [SUM_W-1:0] clamp_lo, clamp_hi;
  logic [TEMP_W-1:0]       target_d;

  always_comb begin
    clamp_lo = (sa_sum_q < ret_low_x) ? ret_low_x : sa_sum_q;
    clamp_hi = (clamp_lo > ret_high_x) ? ret_high_x : clamp_lo;
    if (sa_side_q.zero_span) begin
      target_d = sa_side_q.flow_gt ? cfg_i.ret_high : cfg_i.ret_low;
    end else begin
      target_d = clamp_hi[TEMP_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sb_valid_q <= 1'b0;
    end else if (adv) begin
      sb_valid_q <= sa_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sb_target_q <= target_d;
      sb_side_q   <= sa_side_q;
    end
  end

  // Stage C: excess against the dead band
  logic              sc_valid_q;
  hcvd_dir_e         sc_dir_q, sc_dir_d;
  logic [BEY_W-1:0]  sc_beyond_q, sc_beyond_d;
  logic [TIME_W-1:0] sc_gain_q, sc_gain_d;
  logic [TEMP_W-1:0] sc_target_q, sc_target_d;
  logic signed [DIFF_W-1:0] excess, tol_x, over, under;

  always_comb begin
    tol_x  = $signed({{(DIFF_W-TOL_W){1'b0}}, cfg_i.tol});
    excess = $signed({sb_side_q.ret[TEMP_W-1], sb_side_q.ret})
           - $signed({sb_target_q[TEMP_W-1], sb_target_q});
    sc_target_d = sb_target_q;
    if (sb_side_q.summer) begin
      excess      = '0;
      sc_target_d = SUMMER_TARGET;
    end
    over        = excess - tol_x;
    under       = -excess - tol_x;
    sc_dir_d    = DIR_HALT;
    sc_beyond_d = '0;
    sc_gain_d   = cfg_i.gain_close;
    if (excess > tol_x) begin
      sc_dir_d    = DIR_CLOSE;
      sc_beyond_d = over[BEY_W-1:0];
    end else if (excess < -tol_x) begin
      sc_dir_d    = DIR_OPEN;
      sc_beyond_d = under[BEY_W-1:0];
      sc_gain_d   = cfg_i.gain_open;
    end
    // Sensor fault overrides everything
    if (sb_side_q.err) begin
      sc_dir_d    = DIR_HALT;
      sc_beyond_d = '0;
      sc_target_d = ERROR_TARGET;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_valid_q <= 1'b0;
    end else if (adv) begin
      sc_valid_q <= sb_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sc_dir_q    <= sc_dir_d;
      sc_beyond_q <= sc_beyond_d;
      sc_gain_q   <= sc_gain_d;
      sc_target_q <= sc_target_d;
    end
  end

  // Stage D: gain times excess
  logic              sd_valid_q;
  hcvd_dir_e         sd_dir_q;
  logic [MUL_W-1:0]  sd_mul_q;
  logic [TEMP_W-1:0] sd_target_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sd_valid_q <= 1'b0;
    end else if (adv) begin
      sd_valid_q <= sc_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sd_dir_q    <= sc_dir_q;
      sd_mul_q    <= MUL_W'(sc_gain_q * sc_beyond_q);
      sd_target_q <= sc_target_q;
    end
  end

  // Stage E: add base time, saturate, hold for the output transfer
  logic              out_valid_q;
  hcvd_dir_e         out_dir_q;
  logic [TIME_W-1:0] out_time_q, out_time_d;
  logic [TEMP_W-1:0] out_target_q;
  logic [RUN_W-1:0]  run;

  always_comb begin
    run = {{(RUN_W-TIME_W){1'b0}}, cfg_i.min_time} + {1'b0, sd_mul_q[MUL_W-1:4]};
    if (sd_dir_q == DIR_HALT) begin
      out_time_d = '0;
    end else if (run > {{(RUN_W-TIME_W){1'b0}}, TIME_MAX}) begin
      out_time_d = TIME_MAX;
    end else begin
      out_time_d = run[TIME_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= sd_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_dir_q    <= sd_dir_q;
      out_time_q   <= out_time_d;
      out_target_q <= sd_target_q;
    end
  end

  assign m_valid_o = out_valid_q;
  assign dir_o     = out_dir_q;
  assign time_o    = out_time_q;
  assign target_o  = out_target_q;

endmodule

// File: sv/heating_curve_valve_decision.sv
// Top level of the heating curve valve decision block.
//
//   channel  | direction | payload
//   s_axis   | in        | tdata: flow_temp, return_temp; tuser: sensor_error, summer_mode
//   m_axis   | out       | tdata: direction, motor_time_ms, target_return
//   cfg      | in        | cfg_addr_i register index, cfg_wdata_i value, cfg_we_i write
//
// One sample per cycle is taken and one decision per cycle is given while the output is not stalled.
// From input transfer to output valid a sample passes the front register, the queue entry,
// the magnitude stage, the 27-stage divider and five finish stages.
// A stalled output freezes the back pipeline; the queue of QUEUE_DEPTH entries
// and the front register keep taking samples until they fill.
// Reset loads the register reset values and empties all stages; no clearing pass.
module heating_curve_valve_decision import hcvd_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [31:0]           s_axis_tdata,   // [12:0] flow_temp, [25:13] return_temp
  input  logic [1:0]            s_axis_tuser,   // [0] sensor_error, [1] summer_mode
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [31:0]           m_axis_tdata,   // [1:0] direction, [17:2] motor_time_ms,
                                                // [30:18] target_return
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  hcvd_cfg_t         cfg_q;
  hcvd_item_t        front_item, queue_item;
  logic              push, pop, full, empty;
  logic [1:0]        dir;
  logic [TIME_W-1:0] run_time;
  logic [TEMP_W-1:0] target;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.flow_low   <= RST_FLOW_LOW;
      cfg_q.flow_high  <= RST_FLOW_HIGH;
      cfg_q.ret_low    <= RST_RETURN_LOW;
      cfg_q.ret_high   <= RST_RETURN_HIGH;
      cfg_q.tol        <= RST_TOLERANCE;
      cfg_q.min_time   <= RST_MIN_TIME;
      cfg_q.gain_close <= RST_GAIN_CLOSE;
      cfg_q.gain_open  <= RST_GAIN_OPEN;
    end else if (cfg_we_i) begin
      case (hcvd_reg_e'(cfg_addr_i))
        REG_FLOW_LOW:    cfg_q.flow_low   <= cfg_wdata_i[TEMP_W-1:0];
        REG_FLOW_HIGH:   cfg_q.flow_high  <= cfg_wdata_i[TEMP_W-1:0];
        REG_RETURN_LOW:  cfg_q.ret_low    <= cfg_wdata_i[TEMP_W-1:0];
        REG_RETURN_HIGH: cfg_q.ret_high   <= cfg_wdata_i[TEMP_W-1:0];
        REG_TOLERANCE:   cfg_q.tol        <= cfg_wdata_i[TOL_W-1:0];
        REG_MIN_TIME:    cfg_q.min_time   <= cfg_wdata_i[TIME_W-1:0];
        REG_GAIN_CLOSE:  cfg_q.gain_close <= cfg_wdata_i[TIME_W-1:0];
        REG_GAIN_OPEN:   cfg_q.gain_open  <= cfg_wdata_i[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  hcvd_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .flow_i    (s_axis_tdata[TEMP_W-1:0]),
    .ret_i     (s_axis_tdata[2*TEMP_W-1:TEMP_W]),
    .err_i     (s_axis_tuser[0]),
    .summer_i  (s_axis_tuser[1]),
    .full_i    (full),
    .push_o    (push),
    .item_o    (front_item)
  );

  hcvd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .pop_i   (pop),
    .item_o  (queue_item),
    .full_o  (full),
    .empty_o (empty)
  );

  hcvd_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .empty_i   (empty),
    .item_i    (queue_item),
    .pop_o     (pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .dir_o     (dir),
    .time_o    (run_time),
    .target_o  (target)
  );

  assign m_axis_tdata = {1'b0, target, run_time, dir};

endmodule

// File: sv/hcvd_checker.sv
// Port-level checks of the valve decision block, bound to its top level.
module hcvd_checker import hcvd_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  // A stalled result keeps its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed while stalled");

  // Halt never carries a run time
  a_halt_no_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[1:0] == DIR_HALT) |-> (m_axis_tdata[17:2] == 16'd0))
    else $error("halt with nonzero motor time");

  // Leaving reset: input side open, nothing on the output
  a_reset_exit: assert property (@(posedge clk_i)
    rst_ni && $past(!rst_ni) |-> s_axis_tready && !m_axis_tvalid)
    else $error("pipeline not empty after reset");

endmodule

bind heating_curve_valve_decision hcvd_checker u_hcvd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
